// File: rtl/core/kmc_pkg.sv
// package: shared constants and types for the grayscale k-means block
package kmc_pkg;

    localparam int MAX_CLUSTERS_DEF = 4;
    localparam int MAX_PIXELS_DEF   = 1048576;
    localparam int START_REGS       = 4;
    localparam int SUM_W            = 28;
    localparam int COUNT_W          = 21;
    localparam int PIX_W            = 8;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 8;
    localparam logic [PIX_W-1:0] WHITE = 8'd255;

    typedef enum logic [1:0] {
        CMD_PIXEL   = 2'd0,
        CMD_END     = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLUSTER_COUNT = 3'd0,
        REG_START_0       = 3'd1,
        REG_START_1       = 3'd2,
        REG_START_2       = 3'd3,
        REG_START_3       = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_REPORT
    } state_t;

    // control word handed down the row of cells
    typedef struct packed {
        logic       add;      // add pixel to this cell when it is chosen
        logic       clear;    // clear sum and count
        logic       load;     // load center from start value
        logic       div_start;
        logic       div_step;
        logic       commit;   // take quotient as new center
    } cell_ctrl_t;

endpackage

// File: rtl/core/kmc_if.sv
// interface: valid/ready channel carrying a generic payload
interface kmc_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/kmc_cell.sv
// cell: one cluster's center, sum, count and a restoring divider
module kmc_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  kmc_pkg::cell_ctrl_t         ctrl,
    input  logic                        active,
    input  logic                        chosen,
    input  logic [kmc_pkg::PIX_W-1:0]   pixel,
    input  logic [kmc_pkg::PIX_W-1:0]   start_value,
    // nearest-search chain from the lower neighbor
    input  logic [kmc_pkg::PIX_W:0]     best_d_in,
    input  logic [3:0]                  best_i_in,
    input  logic [3:0]                  my_index,
    output logic [kmc_pkg::PIX_W:0]     best_d_out,
    output logic [3:0]                  best_i_out,
    output logic [kmc_pkg::PIX_W-1:0]   center,
    output logic                        changed
);
    import kmc_pkg::*;

    logic [PIX_W-1:0]   center_reg, center_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0]   rem_reg, rem_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [SUM_W:0]     trial;
    logic [SUM_W:0]     sum_wide;
    logic [PIX_W-1:0]   gap;
    logic [PIX_W-1:0]   mean;

    assign gap = (pixel > center_reg) ? pixel - center_reg : center_reg - pixel;
    always_comb
    begin
        if (active && ({1'b0, gap} < best_d_in))
        begin
            best_d_out = {1'b0, gap};
            best_i_out = my_index;
        end
        else
        begin
            best_d_out = best_d_in;
            best_i_out = best_i_in;
        end
    end

    // one quotient bit per step, shifting the sum through rem
    assign trial = {rem_reg, quo_reg[SUM_W-1]} - {{(SUM_W-COUNT_W+1){1'b0}}, count_reg};
    assign sum_wide = {1'b0, sum_reg} + {{(SUM_W-PIX_W+1){1'b0}}, pixel};
    assign mean = (|quo_reg[SUM_W-1:PIX_W]) ? WHITE : quo_reg[PIX_W-1:0];
    assign changed = active && (count_reg != '0) && (mean != center_reg);
    assign center = center_reg;

    always_comb
    begin
        center_next = center_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        if (ctrl.add && chosen)
        begin
            sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            if (count_reg != '1)
                count_next = count_reg + 1'b1;
        end
        if (ctrl.div_start)
        begin
            rem_next = '0;
            quo_next = sum_reg;
        end
        if (ctrl.div_step)
        begin
            if (!trial[SUM_W])
            begin
                rem_next = trial[SUM_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[SUM_W-2:0], quo_reg[SUM_W-1]};
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (ctrl.commit && active && count_reg != '0)
            center_next = mean;
        if (ctrl.clear)
        begin
            sum_next   = '0;
            count_next = '0;
        end
        if (ctrl.load)
            center_next = start_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            sum_reg    <= '0;
            count_reg  <= '0;
        end
        else
        begin
            center_reg <= center_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (sum_reg == '0 && count_reg == '0))
        else $error("clear did not empty accumulators");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("empty cluster holds a sum");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.add && !chosen && !ctrl.clear && !ctrl.load) |=> $stable(count_reg))
        else $error("unchosen cell counted a pixel");
endmodule

// File: rtl/core/kmeans_gray_pixel_clustering.sv
// top level: grayscale k-means clustering with a row of cluster cells
//
//  channel    dir   payload
//  in_ch      sink  command[1:0], pixel_value[7:0]
//  out_ch     src   result_kind, cluster_index, binary_value, center_value,
//                   converged, last_of_run
//  cfg        in    cfg_we, cfg_idx[2:0], cfg_data[7:0]
//
// a pixel word is labelled on acceptance; its label sits in the output
// register while the next pixel is taken, so pixels stream one per cycle
// unless the output stalls; an end-of-pass word runs 28 divider steps in
// every cell in parallel, then sends one center report per active cluster
// restart gives no result; reset loads the register
// defaults, clears centers, sums and counts, no clearing pass
// output stalls hold the result register and block new input
module kmeans_gray_pixel_clustering #(
    parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    kmc_if.sink                            in_ch,
    kmc_if.source                          out_ch,
    input  logic                           cfg_we,
    input  logic [kmc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [kmc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kmc_pkg::*;

    // counters are sized for MAX_PIXELS_DEF pixels a pass; saturation covers more
    localparam int NCAP = (MAX_CLUSTERS < START_REGS) ? MAX_CLUSTERS : START_REGS;
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    // configuration registers
    logic [2:0]       ccount_reg;
    logic [PIX_W-1:0] start_reg [START_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ccount_reg   <= 3'd2;
            start_reg[0] <= 8'd64;
            start_reg[1] <= 8'd192;
            start_reg[2] <= 8'd224;
            start_reg[3] <= 8'd240;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_CLUSTER_COUNT: ccount_reg   <= cfg_data[2:0];
                REG_START_0:       start_reg[0] <= cfg_data;
                REG_START_1:       start_reg[1] <= cfg_data;
                REG_START_2:       start_reg[2] <= cfg_data;
                REG_START_3:       start_reg[3] <= cfg_data;
                default:           ;
            endcase
        end
    end

    // active cluster count, 1..NCAP
    logic [2:0] k_act;
    always_comb
    begin
        k_act = (ccount_reg == 3'd0) ? 3'd1 : ccount_reg;
        if (k_act > 3'(NCAP))
            k_act = 3'(NCAP);
    end

    // input decode
    cmd_t             cmd;
    logic [PIX_W-1:0] pix;
    assign cmd = cmd_t'(in_ch.data[PIX_W+1:PIX_W]);
    assign pix = in_ch.data[PIX_W-1:0];

    // output register
    logic        ovalid_reg, ovalid_next;
    logic [20:0] opay_reg, opay_next;
    logic        out_free;
    assign out_free = !ovalid_reg || out_ch.ready;

    state_t           state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]       rep_reg, rep_next;
    logic             same_reg, same_next;
    logic             accept;

    assign in_ch.ready = (state_reg == ST_IDLE) && out_free;
    assign accept = in_ch.valid && in_ch.ready;

    // row of cells
    cell_ctrl_t        ctrl;
    logic [PIX_W:0]    bd [NCAP+1];
    logic [3:0]        bi [NCAP+1];
    logic [PIX_W-1:0]  cval [NCAP];
    logic [NCAP-1:0]   chg;
    logic [1:0]        best;

    assign bd[0] = 9'd256;
    assign bi[0] = 4'd0;
    assign best = bi[NCAP][1:0];

    genvar g;
    generate
        for (g = 0; g < NCAP; g++)
        begin : g_cell
            kmc_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .active      (3'(g) < k_act),
                .chosen      (best == 2'(g)),
                .pixel       (pix),
                .start_value (start_reg[g]),
                .best_d_in   (bd[g]),
                .best_i_in   (bi[g]),
                .my_index    (4'(g)),
                .best_d_out  (bd[g+1]),
                .best_i_out  (bi[g+1]),
                .center      (cval[g]),
                .changed     (chg[g])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && cmd == CMD_END)
                    state_next = ST_DIVIDE;
            ST_DIVIDE:
                if (step_reg == STEP_W'(DIV_STEPS))
                    state_next = ST_REPORT;
            ST_REPORT:
                if (out_free && ({1'b0, rep_reg} + 3'd1 == k_act))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    logic [PIX_W-1:0] rep_center;
    assign rep_center = cval[rep_reg];

    always_comb
    begin
        ctrl        = '0;
        step_next   = step_reg;
        rep_next    = rep_reg;
        same_next   = same_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        opay_next   = opay_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_PIXEL:
                        begin
                            ctrl.add    = 1'b1;
                            ovalid_next = 1'b1;
                            opay_next   = {1'b0, best, (best == 2'd0) ? 8'd0 : WHITE,
                                           cval[best], 1'b0, 1'b0};
                        end
                        CMD_END:
                        begin
                            ctrl.div_start = 1'b1;
                            step_next      = '0;
                        end
                        CMD_RESTART:
                        begin
                            ctrl.load  = 1'b1;
                            ctrl.clear = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIVIDE:
            begin
                if (step_reg == STEP_W'(DIV_STEPS))
                begin
                    ctrl.commit = 1'b1;
                    ctrl.clear  = 1'b1;
                    same_next   = !(|chg);
                    rep_next    = '0;
                end
                else
                begin
                    ctrl.div_step = 1'b1;
                    step_next     = step_reg + 1'b1;
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    opay_next   = {1'b1, rep_reg, (rep_reg == 2'd0) ? 8'd0 : WHITE,
                                   rep_center, same_reg,
                                   ({1'b0, rep_reg} + 3'd1 == k_act)};
                    rep_next    = rep_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            step_reg   <= '0;
            rep_reg    <= '0;
            same_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            step_reg   <= step_next;
            rep_reg    <= rep_next;
            same_reg   <= same_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opay_reg <= opay_next;
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = opay_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready)
        else $error("input taken during pass end");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT) |-> ({1'b0, rep_reg} < k_act))
        else $error("report index past active clusters");
endmodule
